@@ src/rtpst_pkg.sv @@
// Shared types and constants for the RTP sequence ring tracker.
`timescale 1ns / 1ps

package rtpst_pkg;

    // Operation codes carried in the mode field
    localparam logic [2:0] MODE_TRACK     = 3'd0;
    localparam logic [2:0] MODE_STORE     = 3'd1;
    localparam logic [2:0] MODE_REMOVE    = 3'd2;
    localparam logic [2:0] MODE_LOOKUP    = 3'd3;
    localparam logic [2:0] MODE_DROP      = 3'd4;
    localparam logic [2:0] MODE_RESET_ALL = 3'd5;
    localparam logic [2:0] MODE_CLR_BELOW = 3'd6;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] seq_number;
        logic [31:0] packet_handle;
    } cmd_t;

    typedef struct packed {
        logic               nack_written;
        logic [15:0]        miss_start;
        logic [15:0]        miss_end;
        logic               slot_found;
        logic [31:0]        found_handle;
        logic [31:0]        highest_extended;
        logic signed [15:0] window_size;
        logic               window_empty;
    } result_t;

    typedef enum logic [2:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_EXEC,
        ST_RESP,
        ST_WIPE,
        ST_SCAN_RD,
        ST_SCAN_WR
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic wipe_wr;
        logic scan_rd;
        logic scan_wr;
        logic cnt_inc;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] mode;
        logic       cnt_last;
    } sts_t;

endpackage

@@ src/rtpst_ctrl.sv @@
// Sequencing state machine for the RTP sequence ring tracker.
`timescale 1ns / 1ps

module rtpst_ctrl
    import rtpst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output ctl_t ctl,
    output logic busy,
    output logic done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT_CLR:
            begin
                if (sts.cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE, ST_RESP:
            begin
                state_next = start ? ST_EXEC : ST_IDLE;
            end
            ST_EXEC:
            begin
                priority if (sts.mode == MODE_RESET_ALL)
                begin
                    state_next = ST_WIPE;
                end
                else if (sts.mode == MODE_CLR_BELOW)
                begin
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_WIPE:
            begin
                if (sts.cnt_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_WR;
            end
            ST_SCAN_WR:
            begin
                state_next = sts.cnt_last ? ST_RESP : ST_SCAN_RD;
            end
            default:
            begin
                state_next = ST_INIT_CLR;
            end
        endcase
    end

    always_comb
    begin
        ctl  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            ST_INIT_CLR, ST_WIPE:
            begin
                ctl.wipe_wr = 1'b1;
                ctl.cnt_inc = 1'b1;
            end
            ST_IDLE:
            begin
                busy     = 1'b0;
                ctl.load = start;
            end
            ST_RESP:
            begin
                busy     = 1'b0;
                done     = 1'b1;
                ctl.load = start;
            end
            ST_EXEC:
            begin
                ctl.exec = 1'b1;
            end
            ST_SCAN_RD:
            begin
                ctl.scan_rd = 1'b1;
            end
            ST_SCAN_WR:
            begin
                ctl.scan_wr = 1'b1;
                ctl.cnt_inc = 1'b1;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

@@ src/rtpst_dp.sv @@
// Window registers, slot memory and result assembly for the RTP sequence ring tracker.
`timescale 1ns / 1ps

module rtpst_dp
    import rtpst_pkg::*;
#(
    parameter int SLOTS       = 1024,
    parameter int HANDLE_BITS = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    input  ctl_t    ctl,
    output sts_t    sts,
    output result_t result
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int SHIFT  = 16 + $clog2(SLOTS);
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + SLOTS - 1) / SLOTS;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = 16 + RECIP_W;
    localparam int WORD_W  = 1 + 16 + HANDLE_BITS;
    localparam logic [15:0]      SLOTS16  = 16'(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // memory word: {valid, seq, handle}
    logic [WORD_W-1:0] slot_mem [SLOTS];
    logic [WORD_W-1:0] rd_data_reg;

    cmd_t        cmd_reg;
    logic [15:0] quot_reg;
    logic        started_reg;
    logic [15:0] begin_reg;
    logic [15:0] end_reg;
    logic [15:0] wrap_reg;
    logic        nack_reg;
    logic [15:0] miss_start_reg;
    logic [15:0] miss_end_reg;
    logic [IDX_W-1:0] cnt_reg;

    logic [PROD_W-1:0] quot_prod;
    logic [15:0]       slot_base;
    logic [15:0]       slot_rem;
    logic [IDX_W-1:0]  slot_idx;
    logic [15:0]       seq;
    logic [15:0]       seq_plus1;
    logic [15:0]       dist_end;
    logic [15:0]       dist_begin;
    logic              cnt_last;

    logic              mem_we;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic              wr_valid;
    logic [63:0]       handle_in;
    logic [63:0]       handle_out;

    logic              rd_valid;
    logic [15:0]       rd_seq;
    logic [HANDLE_BITS-1:0] rd_handle;

    // seq mod SLOTS: exact reciprocal quotient at load, remainder at exec
    assign quot_prod = PROD_W'(cmd.seq_number) * PROD_W'(RECIP);
    assign seq       = cmd_reg.seq_number;
    assign seq_plus1 = 16'(seq + 16'd1);
    assign slot_base = 16'(quot_reg * SLOTS16);
    assign slot_rem  = 16'(seq - slot_base);
    assign slot_idx  = slot_rem[IDX_W-1:0];
    assign dist_end   = 16'(seq - end_reg);
    assign dist_begin = 16'(begin_reg - seq);
    assign cnt_last   = (cnt_reg == LAST_IDX);

    assign rd_valid  = rd_data_reg[WORD_W-1];
    assign rd_seq    = rd_data_reg[WORD_W-2 -: 16];
    assign rd_handle = rd_data_reg[HANDLE_BITS-1:0];

    assign sts.mode     = cmd_reg.mode;
    assign sts.cnt_last = cnt_last;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd;
            quot_reg <= 16'(quot_prod >> SHIFT);
        end
    end

    // slot memory port control
    always_comb
    begin
        handle_in = 64'(cmd_reg.packet_handle);
        wr_valid  = ctl.exec && (cmd_reg.mode == MODE_STORE);
        mem_addr  = ctl.exec ? slot_idx : cnt_reg;
        mem_re    = ctl.exec || ctl.scan_rd;
        mem_we    = ctl.wipe_wr
                 || (ctl.scan_wr && rd_valid && (rd_seq < seq))
                 || (ctl.exec && (cmd_reg.mode == MODE_STORE
                               || cmd_reg.mode == MODE_REMOVE
                               || cmd_reg.mode == MODE_DROP));
        mem_wdata = {wr_valid, seq, handle_in[HANDLE_BITS-1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.cnt_inc)
        begin
            cnt_reg <= cnt_last ? '0 : IDX_W'(cnt_reg + 1'b1);
        end
    end

    // window tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg    <= 1'b0;
            begin_reg      <= '0;
            end_reg        <= '0;
            wrap_reg       <= '0;
            nack_reg       <= 1'b0;
            miss_start_reg <= '0;
            miss_end_reg   <= '0;
        end
        else if (ctl.exec)
        begin
            nack_reg       <= 1'b0;
            miss_start_reg <= '0;
            miss_end_reg   <= '0;
            unique case (cmd_reg.mode)
                MODE_TRACK:
                begin
                    priority if (!started_reg)
                    begin
                        started_reg <= 1'b1;
                        begin_reg   <= seq;
                        end_reg     <= seq_plus1;
                    end
                    else if (!dist_end[15])
                    begin
                        nack_reg       <= 1'b1;
                        miss_start_reg <= end_reg;
                        miss_end_reg   <= seq;
                        if (seq < end_reg)
                        begin
                            wrap_reg <= 16'(wrap_reg + 16'd1);
                        end
                        end_reg <= seq_plus1;
                    end
                    else if (!dist_begin[15] && (dist_begin != 16'd0))
                    begin
                        nack_reg       <= 1'b1;
                        miss_start_reg <= seq;
                        miss_end_reg   <= begin_reg;
                        begin_reg      <= seq;
                    end
                    else
                    begin
                        nack_reg <= 1'b0;
                    end
                end
                MODE_DROP:
                begin
                    begin_reg <= seq_plus1;
                end
                MODE_RESET_ALL:
                begin
                    started_reg <= 1'b0;
                    begin_reg   <= '0;
                    end_reg     <= '0;
                end
                default:
                begin
                    nack_reg <= 1'b0;
                end
            endcase
        end
    end

    // result assembly from registered state
    always_comb
    begin
        handle_out              = 64'(rd_handle);
        result.nack_written     = nack_reg;
        result.miss_start       = miss_start_reg;
        result.miss_end         = miss_end_reg;
        result.slot_found       = (cmd_reg.mode == MODE_LOOKUP) && rd_valid;
        result.found_handle     = result.slot_found ? handle_out[31:0] : 32'd0;
        result.highest_extended = 32'({wrap_reg, 16'h0000} + 32'(end_reg) - 32'd1);
        result.window_size      = 16'(end_reg - begin_reg);
        result.window_empty     = (begin_reg == end_reg);
    end

endmodule

@@ src/rtp_seq_ring_tracker.sv @@
// Top level of the RTP sequence ring tracker: controller plus datapath.
`timescale 1ns / 1ps

// Channel   | Handshake            | Beat
// ----------+----------------------+---------------------------------------
// command   | start & !busy        | cmd    {mode, seq_number, packet_handle}
// result    | done (one cycle)     | result {nack, miss range, slot, window status}
//
// Per-packet modes (track, store, remove, lookup, drop) run the slot memory access
// and window update in an exec state, then present the result in a result state.
// A new command is taken in the cycle the result is shown. Reset-all walks every
// slot; clear-below does a read and a write-back per slot. After rst_n the block
// clears all SLOTS valid flags, one per cycle, with busy high. Results never stall.

module rtp_seq_ring_tracker
    import rtpst_pkg::*;
#(
    parameter int SLOTS       = 1024,
    parameter int HANDLE_BITS = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result
);

    ctl_t ctl;
    sts_t sts;

    // sequencing: init sweep, exec, wipe / scan loops, result cycle
    rtpst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    // window registers, slot memory, slot index arithmetic
    rtpst_dp #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .ctl    (ctl),
        .sts    (sts),
        .result (result)
    );

endmodule

@@ tb/sv/tb_rtp_seq_ring_tracker.sv @@
// Self-checking testbench for the RTP sequence ring tracker.
`timescale 1ns / 1ps

module tb_rtp_seq_ring_tracker;
    import rtpst_pkg::*;

    localparam int SLOTS         = 1024;
    localparam int IDX_W         = $clog2(SLOTS);
    localparam int HANDLE_BITS   = 32;
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Slowest op is clear-below, a read and write-back per slot. Every op
    // returns a beat, so after the last beat the block has nothing left in flight.
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 40;
    // Reset-all and clear-below walk every slot; cap them so the run stays short.
    localparam int SLOW_BUDGET   = 30;
    // Mode code 7 has no operation behind it; the block must leave state alone.
    localparam logic [2:0] MODE_SPARE = 3'd7;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    cmd_t    cmd;
    logic    busy;
    logic    done;
    result_t result;

    // Predictor copy of the tracker state (2-state, so it powers up cleared).
    bit        tracking;
    bit [15:0] win_begin;
    bit [15:0] win_end;
    bit [15:0] wraps;
    bit        slot_used [SLOTS];
    bit [31:0] slot_ref  [SLOTS];
    bit [15:0] slot_tag  [SLOTS];

    result_t pending_results[$];
    int      error_count = 0;
    int      beat_count  = 0;
    int      cycle_count = 0;
    int      burst_left  = 0;
    int      slow_left   = SLOW_BUDGET;

    rtp_seq_ring_tracker #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    // Hard stop in case the block hangs (busy stuck, beats lost).
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, pending_results.size());
            $display("rtp_seq_ring_tracker verification failed");
            $finish;
        end
    end

    // Apply one command to the predictor state and return the beat it yields.
    function automatic result_t step_tracker(cmd_t c);
        result_t          r;
        bit [15:0]        s;
        bit [IDX_W-1:0]   idx;
        bit signed [15:0] ahead;
        bit signed [15:0] behind;
        r      = '0;
        s      = c.seq_number;
        idx    = IDX_W'(s % SLOTS);
        // signed 16-bit distances: end -> seq, and seq -> begin
        ahead  = s - win_end;
        behind = win_begin - s;
        case (c.mode)
            MODE_TRACK:
            begin
                if (!tracking)
                begin
                    // first packet opens the window, no nack
                    tracking  = 1'b1;
                    win_begin = s;
                    win_end   = s + 16'd1;
                end
                else if (ahead >= 0)
                begin
                    // in order or ahead: nack end..seq, even when empty
                    r.nack_written = 1'b1;
                    r.miss_start   = win_end;
                    r.miss_end     = s;
                    if (s < win_end)
                        wraps = wraps + 16'd1;
                    win_end = s + 16'd1;
                end
                else if (behind > 0)
                begin
                    // late packet before begin: window grows backward
                    r.nack_written = 1'b1;
                    r.miss_start   = s;
                    r.miss_end     = win_begin;
                    win_begin      = s;
                end
            end
            MODE_STORE:
            begin
                slot_used[idx] = 1'b1;
                slot_ref[idx]  = c.packet_handle;
                slot_tag[idx]  = s;
            end
            MODE_REMOVE:
                slot_used[idx] = 1'b0;
            MODE_LOOKUP:
            begin
                if (slot_used[idx])
                begin
                    r.slot_found   = 1'b1;
                    r.found_handle = slot_ref[idx];
                end
            end
            MODE_DROP:
            begin
                slot_used[idx] = 1'b0;
                win_begin      = s + 16'd1;
            end
            MODE_RESET_ALL:
            begin
                // wrap count survives a full reset
                for (int i = 0; i < SLOTS; i++)
                    slot_used[IDX_W'(i)] = 1'b0;
                win_begin = '0;
                win_end   = '0;
                tracking  = 1'b0;
            end
            MODE_CLR_BELOW:
            begin
                // plain unsigned compare, no wrap handling
                for (int i = 0; i < SLOTS; i++)
                    if (slot_used[IDX_W'(i)] && slot_tag[IDX_W'(i)] < s)
                        slot_used[IDX_W'(i)] = 1'b0;
            end
            default: ;
        endcase
        r.highest_extended = {wraps, 16'h0000} + {16'h0000, win_end} - 32'd1;
        r.window_size      = win_end - win_begin;
        r.window_empty     = (win_begin == win_end);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (error_count < MAX_REPORTS)
            $display("[%0t] beat %0d %s: got %h, expected %h", $time, beat_count, what,
                     got, want);
        error_count++;
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Result side cannot stall: every done cycle is one beat, taken at this edge.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch("beat with nothing expected", result[31:0], '0);
            else
            begin
                want = pending_results.pop_front();
                check_field("nack_written", 32'(result.nack_written),
                            32'(want.nack_written));
                check_field("miss_start", 32'(result.miss_start), 32'(want.miss_start));
                check_field("miss_end", 32'(result.miss_end), 32'(want.miss_end));
                check_field("slot_found", 32'(result.slot_found), 32'(want.slot_found));
                check_field("found_handle", result.found_handle, want.found_handle);
                check_field("highest_extended", result.highest_extended,
                            want.highest_extended);
                check_field("window_size", 32'(result.window_size),
                            32'(want.window_size));
                check_field("window_empty", 32'(result.window_empty),
                            32'(want.window_empty));
            end
            beat_count++;
        end
    end

    // Sender idle gaps: mostly none or short, a few long, with gap-free bursts.
    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 3)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Drive one command beat, hold it until start & !busy at an edge, then
    // record its expected result. start stays high when no gap follows, so it
    // does not drop before the next call drives the following beat.
    task automatic send_cmd(logic [2:0] m, logic [15:0] s, logic [31:0] h, int gap);
        cmd_t c;
        c.mode          = m;
        c.seq_number    = s;
        c.packet_handle = h;
        cmd   <= c;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_results.push_back(step_tracker(c));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Sender holds off until every expected beat is back, then a short settle.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Window edges: first packet, empty nack, wrap, late packet, inside,
    // the largest forward jump, and end rolling over to zero.
    task automatic test_track_window();
        send_cmd(MODE_TRACK, 16'hFFFD, 32'h0, pick_gap());
        send_cmd(MODE_TRACK, 16'hFFFE, 32'hFFFF_FFFF, pick_gap());
        send_cmd(MODE_TRACK, 16'h0003, 32'h0, pick_gap());
        send_cmd(MODE_TRACK, 16'hFFF0, 32'h0, pick_gap());
        send_cmd(MODE_TRACK, 16'h0001, 32'h0, pick_gap());
        send_cmd(MODE_TRACK, 16'h8003, 32'h0, pick_gap());
        send_cmd(MODE_TRACK, 16'h0004, 32'h0, pick_gap());
        send_cmd(MODE_TRACK, 16'hFFFF, 32'h0, pick_gap());
    endtask

    // Slot access: handle extremes, aliasing by seq mod SLOTS, remove, drop
    // (which here empties the window), and the spare mode code.
    task automatic test_slot_access();
        send_cmd(MODE_STORE, 16'h0000, 32'hFFFF_FFFF, pick_gap());
        send_cmd(MODE_STORE, 16'hFFFF, 32'h0000_0000, pick_gap());
        send_cmd(MODE_LOOKUP, 16'h0000, 32'h0, pick_gap());
        send_cmd(MODE_LOOKUP, 16'hFFFF, 32'h0, pick_gap());
        send_cmd(MODE_STORE, 16'h0400, 32'hA5A5_5A5A, pick_gap());
        send_cmd(MODE_LOOKUP, 16'h0000, 32'h0, pick_gap());
        send_cmd(MODE_REMOVE, 16'h0400, 32'h0, pick_gap());
        send_cmd(MODE_LOOKUP, 16'h0400, 32'h0, pick_gap());
        send_cmd(MODE_DROP, 16'hFFFF, 32'h0, pick_gap());
        send_cmd(MODE_SPARE, 16'($urandom), $urandom, pick_gap());
    endtask

    // Clear-below keeps its plain compare; reset-all keeps the wrap count and
    // lets the next track act as a first packet again.
    task automatic test_clear_modes();
        send_cmd(MODE_STORE, 16'h1000, 32'h0000_0001, pick_gap());
        send_cmd(MODE_STORE, 16'h8001, 32'h0000_0002, pick_gap());
        send_cmd(MODE_STORE, 16'h0FFF, 32'h0000_0003, pick_gap());
        send_cmd(MODE_CLR_BELOW, 16'h1000, 32'h0, pick_gap());
        send_cmd(MODE_LOOKUP, 16'h0FFF, 32'h0, pick_gap());
        send_cmd(MODE_LOOKUP, 16'h8001, 32'h0, pick_gap());
        send_cmd(MODE_RESET_ALL, 16'h0, 32'h0, pick_gap());
        send_cmd(MODE_LOOKUP, 16'h8001, 32'h0, pick_gap());
        send_cmd(MODE_TRACK, 16'h1234, 32'h0, pick_gap());
    endtask

    // Realistic receive stream: mostly in-order tracking with reordering and
    // jumps, buffer traffic close to the newest seq, rare full-slot walks.
    task automatic test_stream_traffic(int n);
        bit [15:0]  cursor;
        logic [15:0] s;
        logic [2:0] m;
        int         r;
        int         k;
        cursor = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(999);
            m = MODE_LOOKUP;
            s = 16'(cursor - $urandom_range(0, 64));
            if (r < 500)
            begin
                m = MODE_TRACK;
                k = $urandom_range(99);
                if (k < 70)
                begin
                    s      = 16'(cursor + $urandom_range(0, 3));
                    cursor = s + 16'd1;
                end
                else if (k < 88)
                    s = 16'(cursor - $urandom_range(1, 64));
                else
                begin
                    // long forward gap, or anywhere at all (reaches the wrap)
                    s      = (k < 95) ? 16'(cursor + $urandom_range(4, 300))
                                      : 16'($urandom);
                    cursor = s + 16'd1;
                end
            end
            else if (r < 700)
            begin
                m = MODE_STORE;
                s = 16'(cursor - $urandom_range(0, 48));
            end
            else if (r < 920 && r >= 850)
                m = MODE_REMOVE;
            else if (r < 960 && r >= 920)
                m = MODE_DROP;
            else if (r < 975 && r >= 960)
            begin
                m = MODE_SPARE;
                s = 16'($urandom);
            end
            else if (r >= 975 && slow_left > 0)
            begin
                slow_left--;
                m = (r < 990) ? MODE_CLR_BELOW : MODE_RESET_ALL;
                s = 16'(cursor - $urandom_range(0, 200));
            end
            // halfway through, let the block drain completely once
            if (i == n / 2)
                wait_idle();
            send_cmd(m, s, $urandom, pick_gap());
        end
    endtask

    // Noise: any mode code (slow modes only within the budget), any seq, any handle.
    task automatic test_random_mix(int n);
        logic [2:0] m;
        for (int i = 0; i < n; i++)
        begin
            m = 3'($urandom_range(7));
            if (m == MODE_RESET_ALL || m == MODE_CLR_BELOW)
            begin
                if (slow_left > 0)
                    slow_left--;
                else
                    m = MODE_LOOKUP;
            end
            send_cmd(m, 16'($urandom), $urandom, pick_gap());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // the block's post-reset clear pass is covered by waiting on busy
        test_track_window();
        test_slot_access();
        test_clear_modes();
        wait_idle();
        test_stream_traffic(1200);
        test_random_mix(450);
        wait_idle();
        if (error_count == 0)
            $display("rtp_seq_ring_tracker verification clean");
        else
            $display("rtp_seq_ring_tracker verification failed");
        $finish;
    end

endmodule
